@@ rtl/core/linked_list_engine_assert.svh @@
// Assertion macros shared by the linked list engine modules.
`ifndef LINKED_LIST_ENGINE_ASSERT_SVH
`define LINKED_LIST_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LLE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("linked list engine check failed");

// The consequent must hold in the cycle after the antecedent.
`define LLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("linked list engine check failed");

`endif

@@ rtl/core/llist_pkg.sv @@
// Types, codes and field widths shared by the linked list engine.
package llist_pkg;

  // Field widths of the item and result channels.
  localparam int FUNC_W    = 2;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 4;
  localparam int LEN_OUT_W = 5;

  // Operation codes carried by an input item.
  typedef enum logic [FUNC_W-1:0] {
    FN_ADD    = 2'd0,
    FN_FIND   = 2'd1,
    FN_INSERT = 2'd2,
    FN_DELETE = 2'd3
  } func_t;

  // Status codes carried by a result item.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_LINK,
    S_INS_NEXT,
    S_INS_CUR,
    S_WALK,
    S_DEL_FREE,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init_step;
    logic accept;
    logic rd_free;
    logic rd_head;
    logic rd_cursor;
    logic set_full;
    logic set_miss;
    logic clr_cursor;
    logic link;
    logic link_front;
    logic ins_next;
    logic ins_cur;
    logic walk;
    logic hit_find;
    logic hit_del;
    logic del_free;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_t func;
    logic  init_last;
    logic  full;
    logic  empty;
    logic  hit;
    logic  last;
    logic  cursor_valid;
  } stat_t;

endpackage

@@ rtl/core/llist_if.sv @@
// Valid/ready channel interfaces for the items and results of the linked list engine.
interface llist_in_if;
  logic                                   valid;
  logic                                   ready;
  logic        [llist_pkg::FUNC_W-1:0]    func;
  logic signed [llist_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface llist_out_if;
  logic                                valid;
  logic                                ready;
  logic [llist_pkg::STATUS_W-1:0]      status;
  logic                                found;
  logic [llist_pkg::POS_W-1:0]         position;
  logic [llist_pkg::LEN_OUT_W-1:0]     length;

  modport source (output valid, output status, output found, output position,
                  output length, input ready);
  modport sink   (input valid, input status, input found, input position,
                  input length, output ready);
endinterface

@@ rtl/core/llist_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module llist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write first in program order; a read of the same address returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/llist_ctrl.sv @@
// Controller state machine of the linked list engine.
`include "linked_list_engine_assert.svh"

module llist_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  llist_pkg::stat_t  stat,
  output llist_pkg::cmd_t   cmd
);

  llist_pkg::state_t state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign in_ready  = (state_r == llist_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      llist_pkg::S_INIT: begin
        if (stat.init_last) state_nxt = llist_pkg::S_IDLE;
      end
      llist_pkg::S_IDLE: begin
        if (in_valid) state_nxt = llist_pkg::S_DISPATCH;
      end
      llist_pkg::S_DISPATCH: begin
        case (stat.func)
          llist_pkg::FN_ADD, llist_pkg::FN_INSERT: begin
            state_nxt = stat.full ? llist_pkg::S_DONE : llist_pkg::S_LINK;
          end
          llist_pkg::FN_FIND, llist_pkg::FN_DELETE: begin
            state_nxt = stat.empty ? llist_pkg::S_DONE : llist_pkg::S_WALK;
          end
          default: state_nxt = llist_pkg::S_DONE;
        endcase
      end
      llist_pkg::S_LINK: begin
        if (stat.func == llist_pkg::FN_ADD || !stat.cursor_valid) begin
          state_nxt = llist_pkg::S_DONE;
        end else begin
          state_nxt = llist_pkg::S_INS_NEXT;
        end
      end
      llist_pkg::S_INS_NEXT: state_nxt = llist_pkg::S_INS_CUR;
      llist_pkg::S_INS_CUR:  state_nxt = llist_pkg::S_DONE;
      llist_pkg::S_WALK: begin
        if (stat.hit) begin
          state_nxt = (stat.func == llist_pkg::FN_DELETE) ? llist_pkg::S_DEL_FREE
                                                          : llist_pkg::S_DONE;
        end else if (stat.last) begin
          state_nxt = llist_pkg::S_DONE;
        end
      end
      llist_pkg::S_DEL_FREE: state_nxt = llist_pkg::S_DONE;
      llist_pkg::S_DONE: begin
        if (out_free) state_nxt = llist_pkg::S_IDLE;
      end
      default: state_nxt = llist_pkg::S_INIT;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    case (state_r)
      llist_pkg::S_INIT: cmd.init_step = 1'b1;
      llist_pkg::S_IDLE: cmd.accept = in_valid;
      llist_pkg::S_DISPATCH: begin
        case (stat.func)
          llist_pkg::FN_ADD, llist_pkg::FN_INSERT: begin
            cmd.set_full = stat.full;
            cmd.rd_free  = !stat.full;
          end
          llist_pkg::FN_FIND: begin
            cmd.set_miss   = stat.empty;
            cmd.clr_cursor = stat.empty;
            cmd.rd_head    = !stat.empty;
          end
          llist_pkg::FN_DELETE: begin
            cmd.set_miss = stat.empty;
            cmd.rd_head  = !stat.empty;
          end
          default: cmd.set_miss = 1'b1;
        endcase
      end
      llist_pkg::S_LINK: begin
        cmd.link = 1'b1;
        if (stat.func == llist_pkg::FN_ADD || !stat.cursor_valid) begin
          cmd.link_front = 1'b1;
        end else begin
          cmd.rd_cursor = 1'b1;
        end
      end
      llist_pkg::S_INS_NEXT: cmd.ins_next = 1'b1;
      llist_pkg::S_INS_CUR:  cmd.ins_cur  = 1'b1;
      llist_pkg::S_WALK: begin
        if (stat.hit) begin
          cmd.hit_find = (stat.func == llist_pkg::FN_FIND);
          cmd.hit_del  = (stat.func == llist_pkg::FN_DELETE);
        end else if (stat.last) begin
          cmd.set_miss   = 1'b1;
          cmd.clr_cursor = (stat.func == llist_pkg::FN_FIND);
        end else begin
          cmd.walk = 1'b1;
        end
      end
      llist_pkg::S_DEL_FREE: cmd.del_free = 1'b1;
      llist_pkg::S_DONE:     cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

  // The result register stays full until the sink takes the item.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= llist_pkg::S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // At most one next-pointer write is commanded in any cycle.
  `LLE_ASSERT_SAME(a_one_link_write, clk, rst_n, 1'b1, $onehot0({cmd.init_step, cmd.link_front, cmd.ins_next, cmd.ins_cur, cmd.hit_del, cmd.del_free}))
  // A walk that matched does not step on to the next node.
  `LLE_ASSERT_SAME(a_hit_stops_walk, clk, rst_n, state_r == llist_pkg::S_WALK && stat.hit, !cmd.walk)
  // Handing over a result returns the controller to idle.
  `LLE_ASSERT_NEXT(a_done_to_idle, clk, rst_n, cmd.load_out, state_r == llist_pkg::S_IDLE && out_valid_r)

endmodule

@@ rtl/core/llist_dp.sv @@
// Datapath of the linked list engine: node pool memories, list pointers and result registers.
`include "linked_list_engine_assert.svh"

module llist_dp #(
  parameter int POOL_DEPTH = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  llist_pkg::cmd_t                         cmd,
  output llist_pkg::stat_t                        stat,
  input  logic        [llist_pkg::FUNC_W-1:0]     in_func,
  input  logic signed [llist_pkg::VALUE_W-1:0]    in_value,
  output logic        [llist_pkg::STATUS_W-1:0]   out_status,
  output logic                                    out_found,
  output logic        [llist_pkg::POS_W-1:0]      out_position,
  output logic        [llist_pkg::LEN_OUT_W-1:0]  out_length
);

  localparam int IDX_W = $clog2(POOL_DEPTH);
  localparam int LEN_W = $clog2(POOL_DEPTH + 1);

  // List state.
  logic [IDX_W-1:0]      head_r, free_r, cursor_r;
  logic                  cursor_valid_r;
  logic [LEN_W-1:0]      len_r;
  logic [IDX_W-1:0]      init_cnt_r;

  // Per-item working registers.
  llist_pkg::func_t      func_r;
  logic [DATA_WIDTH-1:0] value_r;
  logic [IDX_W-1:0]      cur_r, prev_r, alloc_r, pos_r;
  logic                  prev_valid_r;
  llist_pkg::status_t    res_status_r;
  logic                  res_found_r;

  // Result payload registers.
  logic [llist_pkg::STATUS_W-1:0]  out_status_r;
  logic                            out_found_r;
  logic [llist_pkg::POS_W-1:0]     out_position_r;
  logic [llist_pkg::LEN_OUT_W-1:0] out_length_r;

  // Memory ports.
  logic [IDX_W-1:0]      raddr;
  logic                  val_we;
  logic [DATA_WIDTH-1:0] rd_val;
  logic                  nxt_we;
  logic [IDX_W-1:0]      nxt_waddr, nxt_wdata, rd_next;
  logic                  init_last;

  assign init_last = (init_cnt_r == IDX_W'(POOL_DEPTH - 1));

  // Node values and next pointers share one read address.
  llist_ram #(.WIDTH(DATA_WIDTH), .DEPTH(POOL_DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (free_r),
    .wdata (value_r),
    .raddr (raddr),
    .rdata (rd_val)
  );

  llist_ram #(.WIDTH(IDX_W), .DEPTH(POOL_DEPTH)) u_next_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .raddr (raddr),
    .rdata (rd_next)
  );

  // Read address: a walk follows the pointer that the memory just returned.
  always_comb begin
    if (cmd.rd_free) begin
      raddr = free_r;
    end else if (cmd.rd_head) begin
      raddr = head_r;
    end else if (cmd.rd_cursor) begin
      raddr = cursor_r;
    end else if (cmd.walk) begin
      raddr = rd_next;
    end else begin
      raddr = cur_r;
    end
  end

  assign val_we = cmd.link;

  // Next-pointer write port.
  always_comb begin
    nxt_we    = 1'b1;
    nxt_waddr = cur_r;
    nxt_wdata = free_r;
    if (cmd.init_step) begin
      nxt_waddr = init_cnt_r;
      nxt_wdata = init_last ? '0 : init_cnt_r + IDX_W'(1);
    end else if (cmd.link_front) begin
      nxt_waddr = free_r;
      nxt_wdata = head_r;
    end else if (cmd.ins_next) begin
      nxt_waddr = alloc_r;
      nxt_wdata = rd_next;
    end else if (cmd.ins_cur) begin
      nxt_waddr = cursor_r;
      nxt_wdata = alloc_r;
    end else if (cmd.hit_del && prev_valid_r) begin
      nxt_waddr = prev_r;
      nxt_wdata = rd_next;
    end else if (!cmd.del_free) begin
      nxt_we = 1'b0;
    end
  end

  // Status to the controller.
  always_comb begin
    stat.func         = func_r;
    stat.init_last    = init_last;
    stat.full         = (len_r == LEN_W'(POOL_DEPTH));
    stat.empty        = (len_r == '0);
    stat.hit          = (rd_val == value_r);
    stat.last         = (LEN_W'(pos_r) + LEN_W'(1) == len_r);
    stat.cursor_valid = cursor_valid_r;
  end

  // List pointers, length and cursor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r         <= '0;
      free_r         <= '0;
      cursor_r       <= '0;
      cursor_valid_r <= 1'b0;
      len_r          <= '0;
      init_cnt_r     <= '0;
    end else begin
      if (cmd.init_step) begin
        init_cnt_r <= init_cnt_r + IDX_W'(1);
      end
      if (cmd.link) begin
        free_r <= rd_next;
        len_r  <= len_r + LEN_W'(1);
      end
      if (cmd.link_front) begin
        head_r <= free_r;
      end
      if (cmd.clr_cursor) begin
        cursor_valid_r <= 1'b0;
      end
      if (cmd.hit_find) begin
        cursor_r       <= cur_r;
        cursor_valid_r <= 1'b1;
      end
      if (cmd.hit_del && !prev_valid_r) begin
        head_r <= rd_next;
      end
      if (cmd.del_free) begin
        free_r <= cur_r;
        len_r  <= len_r - LEN_W'(1);
        if (cursor_valid_r && cursor_r == cur_r) begin
          cursor_valid_r <= 1'b0;
        end
      end
    end
  end

  // Working registers of the item in progress.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r       <= llist_pkg::func_t'(in_func);
      value_r      <= DATA_WIDTH'(in_value);
      pos_r        <= '0;
      res_status_r <= llist_pkg::ST_DONE;
      res_found_r  <= 1'b0;
    end
    if (cmd.link) begin
      alloc_r <= free_r;
    end
    if (cmd.rd_head) begin
      cur_r        <= head_r;
      prev_valid_r <= 1'b0;
      pos_r        <= '0;
    end
    if (cmd.walk) begin
      cur_r        <= rd_next;
      prev_r       <= cur_r;
      prev_valid_r <= 1'b1;
      pos_r        <= pos_r + IDX_W'(1);
    end
    if (cmd.set_full) begin
      res_status_r <= llist_pkg::ST_FULL;
    end
    if (cmd.set_miss) begin
      res_status_r <= llist_pkg::ST_MISS;
      res_found_r  <= 1'b0;
    end
    if (cmd.hit_find || cmd.hit_del) begin
      res_found_r <= 1'b1;
    end
  end

  // Result item register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r   <= res_status_r;
      out_found_r    <= res_found_r;
      out_position_r <= res_found_r ? llist_pkg::POS_W'(pos_r) : '0;
      out_length_r   <= llist_pkg::LEN_OUT_W'(len_r);
    end
  end

  assign out_status   = out_status_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;
  assign out_length   = out_length_r;

  // The list never holds more nodes than the pool.
  `LLE_ASSERT_SAME(a_len_bound, clk, rst_n, 1'b1, len_r <= LEN_W'(POOL_DEPTH))
  // A node is taken from the pool only while the pool has one to give.
  `LLE_ASSERT_SAME(a_link_not_full, clk, rst_n, cmd.link, len_r != LEN_W'(POOL_DEPTH))
  // A node is freed only from a list that holds one.
  `LLE_ASSERT_SAME(a_free_not_empty, clk, rst_n, cmd.del_free, len_r != '0)

endmodule

@@ rtl/core/linked_list_engine.sv @@
// Top level of the linked list engine: controller, datapath and channel wiring.
//
// The engine keeps a singly linked list of values in a pool of POOL_DEPTH nodes and takes
// one item at a time; each item yields one result. Add links the new node at the front;
// insert links it after the cursor when there is one, else at the front. An add or insert
// into a full pool is refused. Find and delete walk from the front and visit at most the
// list length of nodes, and a delete that matches then returns the node to the pool. The
// walk reads one node per cycle from the node memories, whose single read port sets that
// figure. A new item is accepted while the previous result still waits in the output
// register; a result that the sink does not take holds up the item after it. After reset
// the engine builds the free chain and accepts no item until that pass ends.
module linked_list_engine #(
  parameter int POOL_DEPTH = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  llist_in_if.sink           in_chan,
  llist_out_if.source        out_chan
);

  llist_pkg::cmd_t  cmd;
  llist_pkg::stat_t stat;

  // Sequencing of each item.
  llist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Node pool, pointers and result payload.
  llist_dp #(
    .POOL_DEPTH (POOL_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_func      (in_chan.func),
    .in_value     (in_chan.value),
    .out_status   (out_chan.status),
    .out_found    (out_chan.found),
    .out_position (out_chan.position),
    .out_length   (out_chan.length)
  );

endmodule

@@ tb/sv/llist_tb_pkg.sv @@
`timescale 1ns / 100ps
// Scoreboard class that tracks the list contents and checks each result item of the engine.
package llist_tb_pkg;
  import llist_pkg::*;

  localparam int POOL_NODES = 16;
  localparam int NODE_W     = 4;

  // One expected result item.
  typedef struct packed {
    status_t              status;
    logic                 found;
    logic [POS_W-1:0]     position;
    logic [LEN_OUT_W-1:0] length;
  } llist_result_t;

  class llist_scoreboard;
    logic [VALUE_W-1:0] node_val[POOL_NODES];
    logic [NODE_W-1:0]  node_nxt[POOL_NODES];
    logic [NODE_W-1:0]  head;
    logic [NODE_W-1:0]  free_head;
    logic [NODE_W-1:0]  cursor;
    bit                 head_ok;
    bit                 cursor_ok;
    int unsigned        length;
    llist_result_t      pending[$];
    int                 errors;
    int                 items;
    int                 results;
    int                 hits;
    int                 misses;
    int                 fulls;

    // Start from the post-reset list: empty, with every node on the free chain.
    function new();
      for (int i = 0; i < POOL_NODES; i++) begin
        node_val[i] = '0;
        node_nxt[i] = NODE_W'((i + 1) % POOL_NODES);
      end
      head      = '0;
      free_head = '0;
      cursor    = '0;
      head_ok   = 1'b0;
      cursor_ok = 1'b0;
      length    = 0;
      errors    = 0;
      items     = 0;
      results   = 0;
      hits      = 0;
      misses    = 0;
      fulls     = 0;
    endfunction

    // Walk from the front for the first node holding v; never follows the tail's link.
    function bit locate(input logic [VALUE_W-1:0] v, output logic [NODE_W-1:0] node,
                        output logic [NODE_W-1:0] prev, output bit has_prev, output int pos);
      logic [NODE_W-1:0] hop;
      hop      = head;
      node     = '0;
      prev     = '0;
      has_prev = 1'b0;
      pos      = 0;
      for (int i = 0; i < length; i++) begin
        if (node_val[hop] == v) begin
          node = hop;
          pos  = i;
          return 1'b1;
        end
        prev     = hop;
        has_prev = 1'b1;
        hop      = node_nxt[hop];
      end
      return 1'b0;
    endfunction

    // Apply one accepted input item to the list and queue the result it should give.
    function void note_item(input func_t f, input logic [VALUE_W-1:0] v);
      llist_result_t     r;
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] prev;
      logic [NODE_W-1:0] n;
      bit                has_prev;
      int                pos;
      r.status   = ST_DONE;
      r.found    = 1'b0;
      r.position = '0;
      items++;
      case (f)
        FN_ADD, FN_INSERT: begin
          if (length >= POOL_NODES) begin
            r.status = ST_FULL;
          end else begin
            n           = free_head;
            free_head   = node_nxt[n];
            node_val[n] = v;
            length++;
            // Insert goes after the cursor when there is one, otherwise to the front.
            if (f == FN_INSERT && cursor_ok) begin
              node_nxt[n]      = node_nxt[cursor];
              node_nxt[cursor] = n;
            end else begin
              node_nxt[n] = head;
              head        = n;
              head_ok     = 1'b1;
            end
          end
        end
        FN_FIND: begin
          if (locate(v, node, prev, has_prev, pos)) begin
            cursor     = node;
            cursor_ok  = 1'b1;
            r.found    = 1'b1;
            r.position = POS_W'(pos);
          end else begin
            cursor_ok = 1'b0;
            r.status  = ST_MISS;
          end
        end
        default: begin
          if (locate(v, node, prev, has_prev, pos)) begin
            if (has_prev) begin
              node_nxt[prev] = node_nxt[node];
            end else begin
              head = node_nxt[node];
            end
            node_nxt[node] = free_head;
            free_head      = node;
            length--;
            if (length == 0) begin
              head_ok = 1'b0;
              head    = '0;
            end
            // A deleted cursor node leaves no cursor behind.
            if (cursor_ok && cursor == node) begin
              cursor_ok = 1'b0;
            end
            r.found    = 1'b1;
            r.position = POS_W'(pos);
          end else begin
            r.status = ST_MISS;
          end
        end
      endcase
      r.length = LEN_OUT_W'(length);
      if (r.found) hits++;
      if (r.status == ST_MISS) misses++;
      if (r.status == ST_FULL) fulls++;
      pending.push_back(r);
    endfunction

    // Compare one accepted result item with the oldest expectation.
    function void check_result(input logic [STATUS_W-1:0] status, input logic found,
                               input logic [POS_W-1:0] position,
                               input logic [LEN_OUT_W-1:0] length_out);
      llist_result_t want;
      results++;
      if (pending.size() == 0) begin
        $error("result item with no item outstanding: status %0d length %0d",
               status, length_out);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        errors++;
      end
      if (found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, found);
        errors++;
      end
      if (position !== want.position) begin
        $error("position: expected %0d, actual %0d", want.position, position);
        errors++;
      end
      if (length_out !== want.length) begin
        $error("length: expected %0d, actual %0d", want.length, length_out);
        errors++;
      end
    endfunction
  endclass

endpackage

@@ tb/sv/tb_linked_list_engine.sv @@
`timescale 1ns / 100ps
// Top-level testbench of the linked list engine: clock, reset, item drivers and checks.
module tb_linked_list_engine;
  import llist_pkg::*;
  import llist_tb_pkg::*;

  localparam int IDLE_PCT     = 31;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1000;

  logic clk;
  logic rst_n;
  int   quiet_cycles;

  llist_in_if  in_chan();
  llist_out_if out_chan();

  llist_scoreboard sb;

  linked_list_engine #(
    .POOL_DEPTH(POOL_NODES),
    .DATA_WIDTH(VALUE_W)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Random gaps on either side, except over one stretch of items where both run flat out.
  function automatic bit take_gap();
    if (sb != null && sb.items >= 330 && sb.items < 480) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  // The result side stalls at random.
  always @(negedge clk) begin
    out_chan.ready <= !take_gap();
  end

  // Check every accepted result item.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      sb.check_result(out_chan.status, out_chan.found, out_chan.position, out_chan.length);
    end
  end

  // Watchdog on cycles where neither channel moves an item.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one item from a falling edge, hold it until accepted, return at a falling edge.
  task automatic send_item(input func_t f, input logic [VALUE_W-1:0] v);
    while (take_gap()) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.func  <= f;
    in_chan.value <= v;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_item(f, v);
    @(negedge clk);
  endtask

  initial begin
    logic [VALUE_W-1:0] palette[16];
    logic [VALUE_W-1:0] v;
    func_t              f;
    int                 grow_pct;

    sb             = new();
    quiet_cycles   = 0;
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.func   = FN_ADD;
    in_chan.value  = '0;
    out_chan.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: misses on an empty list and insert with no cursor.
    send_item(FN_FIND, 32'd5);
    send_item(FN_DELETE, 32'd5);
    send_item(FN_INSERT, 32'd1);
    // Extremes of the value field at the front.
    send_item(FN_ADD, 32'h7fff_ffff);
    send_item(FN_ADD, 32'h8000_0000);
    send_item(FN_ADD, 32'hffff_ffff);
    send_item(FN_ADD, 32'h0000_0000);
    // Insert after the tail, then in the middle.
    send_item(FN_FIND, 32'd1);
    send_item(FN_INSERT, 32'd2);
    send_item(FN_FIND, 32'h8000_0000);
    send_item(FN_INSERT, 32'd3);
    // Deleting the cursor node sends the next insert to the front.
    send_item(FN_DELETE, 32'h8000_0000);
    send_item(FN_INSERT, 32'd4);
    send_item(FN_DELETE, 32'd4);
    send_item(FN_FIND, 32'd99);
    // Fill the pool, refuse further nodes, then reach the deepest position.
    while (sb.length < POOL_NODES) begin
      send_item(FN_ADD, 32'd100 + sb.length);
    end
    send_item(FN_FIND, 32'd2);
    send_item(FN_ADD, 32'd7);
    send_item(FN_INSERT, 32'd8);
    send_item(FN_DELETE, 32'd2);

    // Random: values mostly from a small palette so finds and deletes hit often.
    foreach (palette[i]) palette[i] = $urandom;
    palette[0] = 32'h8000_0000;
    palette[1] = 32'h7fff_ffff;
    palette[2] = 32'h0000_0000;
    palette[3] = 32'hffff_ffff;
    grow_pct = 50;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Drift between filling and draining the pool.
      if (i % 100 == 0) grow_pct = $urandom_range(15, 70);
      if ($urandom_range(99) < grow_pct) begin
        f = $urandom_range(1) ? FN_ADD : FN_INSERT;
      end else begin
        f = $urandom_range(1) ? FN_FIND : FN_DELETE;
      end
      v = ($urandom_range(9) < 8) ? palette[$urandom_range(15)] : VALUE_W'($urandom);
      send_item(f, v);
    end
    in_chan.valid <= 1'b0;

    // Let the last results come out, then watch for strays.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items and checked %0d results.", sb.items, sb.results);
    $display("Matches %0d, misses %0d, pool-full refusals %0d.", sb.hits, sb.misses,
             sb.fulls);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
